// ----- sv/mi3_pkg.sv -----
// constants and widths for the 3x3 adjugate matrix inverse
package mi3_pkg;
  localparam int EW   = 32;              // element width
  localparam int FB   = 16;              // fraction bits
  localparam int PW   = 2 * EW;          // element product width
  localparam int CW   = 2 * EW + 1;      // cofactor width
  localparam int TW   = 2 * EW + 1;      // partial product width for the determinant
  localparam int DETW = 3 * EW + 3;      // determinant width
  localparam int NS   = 2 * FB;          // numerator scale
  localparam int NW   = PW + NS;         // numerator magnitude width
  localparam int QB   = EW + 1;          // quotient bits developed by the divider
  localparam int RW   = DETW + 1;        // partial remainder width
  localparam int DATW = ((9 * EW + 7) / 8) * 8;
  localparam logic [QB:0] LIM_NEG = (QB + 1)'(1) << (EW - 1);
  localparam logic [QB:0] LIM_POS = LIM_NEG - (QB + 1)'(1);
endpackage

// ----- sv/matrix_inverse_3x3.sv -----
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
//
//  channel  | signals                        | contents
//  ---------+--------------------------------+-------------------------------------
//  in       | s_axis_tvalid/tready/tdata     | matrix a, row-major, Q16.16
//  out      | m_axis_tvalid/tready/tdata/user| inverse, row-major, Q16.16; singular
//
// one matrix enters per cycle while the pipe is not stalled; the pipe holds the
// products/cofactor/determinant front end, the 33 restoring divide steps
// that share each determinant across nine lanes, and the output register.
// rst clears only the valid bits; data registers carry no reset.
// all stages advance together whenever the output register is empty or taken,
// so a stall freezes the whole pipe and nothing is dropped or repeated.
module matrix_inverse_3x3
  import mi3_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [DATW-1:0] s_axis_tdata,  // in_r0c0, in_r0c1, .. in_r2c2, 32 bits each
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [DATW-1:0] m_axis_tdata,  // out_r0c0, out_r0c1, .. out_r2c2, 32 bits each
  output logic            m_axis_tuser   // singular
);

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---- stage 1: eighteen element products
  logic signed [EW-1:0] ain [0:8];
  logic signed [PW-1:0] p0 [0:8];
  logic signed [PW-1:0] p1 [0:8];
  logic signed [EW-1:0] a1 [0:2];
  logic v1;

  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign ain[i] = s_axis_tdata[i*EW +: EW];
  end

  for (genvar y = 0; y < 3; y++) begin : g_row
    for (genvar x = 0; x < 3; x++) begin : g_col
      localparam int C0 = (x + 1) % 3;
      localparam int C1 = (x + 2) % 3;
      localparam int R0 = 3 * ((y + 1) % 3);
      localparam int R1 = 3 * ((y + 2) % 3);
      always_ff @(posedge clk) begin
        if (en) begin
          // adjugate is the transposed cofactor matrix
          p0[x*3+y] <= ain[R0+C0] * ain[R1+C1];
          p1[x*3+y] <= ain[R0+C1] * ain[R1+C0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) a1[i] <= ain[i];
    end
  end

  // ---- stage 2: cofactors
  logic signed [CW-1:0] adj2 [0:8];
  logic signed [EW-1:0] a2 [0:2];
  logic v2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) adj2[i] <= CW'(p0[i]) - CW'(p1[i]);
      for (int i = 0; i < 3; i++) a2[i] <= a1[i];
    end
  end

  // ---- stage 3: first row times its cofactors, split in two partial products
  logic signed [CW-1:0] adj3 [0:8];
  logic signed [TW-1:0] pl3 [0:2];
  logic signed [TW-1:0] ph3 [0:2];
  logic v3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) adj3[i] <= adj2[i];
      for (int x = 0; x < 3; x++) begin
        pl3[x] <= a2[x] * $signed({1'b0, adj2[x*3][EW-1:0]});
        ph3[x] <= a2[x] * $signed(adj2[x*3][CW-1:EW]);
      end
    end
  end

  // ---- stage 4: recombine partial products
  logic signed [CW-1:0]   adj4 [0:8];
  logic signed [DETW-1:0] t4 [0:2];
  logic v4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) adj4[i] <= adj3[i];
      for (int x = 0; x < 3; x++) t4[x] <= (DETW'(ph3[x]) <<< EW) + DETW'(pl3[x]);
    end
  end

  // ---- stage 5: determinant
  logic signed [CW-1:0]   adj5 [0:8];
  logic signed [DETW-1:0] det5;
  logic v5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) adj5[i] <= adj4[i];
      det5 <= t4[0] + t4[1] + t4[2];
    end
  end

  // ---- stage 6: magnitudes and divider setup
  logic [RW-1:0]   drem [0:QB][0:8];
  logic [QB-1:0]   dq   [0:QB][0:8];
  logic [QB-1:0]   dnl  [0:QB][0:8];
  logic            dng  [0:QB][0:8];
  logic            dov  [0:QB][0:8];
  logic [DETW-1:0] dd   [0:QB];
  logic            dz   [0:QB];
  logic            dv   [0:QB];

  logic [DETW-1:0] det_neg;
  logic [DETW-1:0] dmag;
  logic [CW-1:0]   cneg [0:8];
  logic [NW-1:0]   num  [0:8];

  always_comb begin
    det_neg = -det5;
    dmag = det5[DETW-1] ? det_neg : det5;
    for (int i = 0; i < 9; i++) begin
      cneg[i] = -adj5[i];
      num[i] = {(adj5[i][CW-1] ? cneg[i][PW-1:0] : adj5[i][PW-1:0]), {NS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= dmag;
      dz[0] <= (det5 == '0);
      for (int i = 0; i < 9; i++) begin
        drem[0][i] <= RW'(num[i][NW-1:QB]);
        dnl[0][i]  <= num[i][QB-1:0];
        dq[0][i]   <= '0;
        dng[0][i]  <= adj5[i][CW-1] ^ det5[DETW-1];
        // quotient would need more bits than the divider develops
        dov[0][i]  <= (RW'(num[i][NW-1:QB]) >= RW'(dmag));
      end
    end
  end

  // ---- divider: one quotient bit per stage in each of nine lanes
  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [RW-1:0] trial [0:8];
    logic [RW-1:0] diff  [0:8];
    logic          ge    [0:8];

    always_comb begin
      for (int i = 0; i < 9; i++) begin
        trial[i] = {drem[s][i][RW-2:0], dnl[s][i][QB-1-s]};
        diff[i]  = trial[i] - RW'(dd[s]);
        ge[i]    = (trial[i] >= RW'(dd[s]));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[s+1] <= dd[s];
        dz[s+1] <= dz[s];
        for (int i = 0; i < 9; i++) begin
          drem[s+1][i] <= ge[i] ? diff[i] : trial[i];
          dq[s+1][i]   <= {dq[s][i][QB-2:0], ge[i]};
          dnl[s+1][i]  <= dnl[s][i];
          dng[s+1][i]  <= dng[s][i];
          dov[s+1][i]  <= dov[s][i];
        end
      end
    end
  end

  // ---- output: round half away from zero, saturate, sign
  logic [QB:0]   qr   [0:8];
  logic [QB:0]   lim  [0:8];
  logic [QB:0]   qm   [0:8];
  logic [QB:0]   qs   [0:8];
  logic [DATW-1:0] odata;

  always_comb begin
    odata = '0;
    for (int i = 0; i < 9; i++) begin
      qr[i] = {1'b0, dq[QB][i]} +
              (QB + 1)'({drem[QB][i], 1'b0} >= (RW + 1)'(dd[QB]));
      lim[i] = dng[QB][i] ? LIM_NEG : LIM_POS;
      qm[i] = (dov[QB][i] || qr[i] > lim[i]) ? lim[i] : qr[i];
      qs[i] = dng[QB][i] ? -qm[i] : qm[i];
      odata[i*EW +: EW] = dz[QB] ? '0 : qs[i][EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= odata;
      m_axis_tuser <= dz[QB];
    end
  end

  // ---- valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int s = 0; s <= QB; s++) dv[s] <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dv[0] <= v5;
      for (int s = 0; s < QB; s++) dv[s+1] <= dv[s];
      m_axis_tvalid <= dv[QB];
    end
  end

endmodule
